FILE: hdl/ffba_pkg.sv
package ffba_pkg;

  typedef struct packed {
    logic        func;
    logic [15:0] request_size;
    logic [15:0] free_start;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_start;
    logic [15:0] granted_size;
  } rsp_t;

  localparam logic       FUNC_ALLOC  = 1'b0;
  localparam logic       FUNC_FREE   = 1'b1;
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_BADFREE  = 2'd2;

  localparam logic [1:0] REG_REGION  = 2'd0;
  localparam logic [1:0] REG_THRESH  = 2'd1;

  localparam logic [15:0] RESET_REGION = 16'd10000;
  localparam logic [15:0] RESET_THRESH = 16'd100;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_RD,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FREE_NEXT,
    S_FREE_PREV,
    S_RESP
  } state_e;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // capture request, start scan at entry 0
    OP_INIT,     // write one entry per cycle: entry 0 to the region size, the rest cleared
    OP_READ,     // issue read of current index
    OP_EXAM,     // examine read data
    OP_UP,       // one step of upward shift
    OP_DN,       // one step of downward shift
    OP_NEXT,     // free: check/merge next entry
    OP_PREV      // free: check/merge previous entry
  } op_e;

  typedef struct packed {
    logic hit;       // alloc fit found / free target found
    logic miss;      // end of scan without a hit
    logic split;     // hit needs a split
    logic shift_done;
    logic merge;     // neighbor is free, merge needed
    logic init_done;
  } sts_t;

endpackage

FILE: hdl/ffba_datapath.sv
module ffba_datapath #(
  parameter int unsigned MaxBlocks = 64,
  parameter int unsigned IdxW = 6,
  parameter int unsigned CntW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffba_pkg::op_e   op_i,
  input  ffba_pkg::req_t  req_i,
  input  logic [15:0]     region_i,
  input  logic [15:0]     thresh_i,
  output ffba_pkg::sts_t  sts_o,
  output ffba_pkg::rsp_t  rsp_o
);

  // table memory: {in_use, size}
  logic [16:0] mem [MaxBlocks];
  logic [16:0] rd_q;
  logic        we;
  logic [IdxW-1:0] wa, ra;
  logic [16:0] wd;

  ffba_pkg::req_t  req_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;   // scan/shift index
  logic [CntW-1:0] hit_q, hit_d;   // located entry
  logic [16:0]     start_q, start_d;
  logic [15:0]     left_q, left_d;
  logic [15:0]     acc_q, acc_d;   // merged size of freed block
  logic [15:0]     need;
  ffba_pkg::rsp_t  rsp_q, rsp_d;
  logic [1:0]      ph_q, ph_d;     // sub-step of shift/merge: 0 read issued,1 data

  assign need = (req_q.request_size == 16'd0) ? 16'd1 : req_q.request_size;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntW'(1);
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == ffba_pkg::OP_LOAD) req_q <= req_i;
    hit_q   <= hit_d;
    start_q <= start_d;
    left_q  <= left_d;
    acc_q   <= acc_d;
    rsp_q   <= rsp_d;
    ph_q    <= ph_d;
  end

  always_comb begin
    cnt_d = cnt_q; idx_d = idx_q; hit_d = hit_q; start_d = start_q;
    left_d = left_q; acc_d = acc_q; rsp_d = rsp_q; ph_d = ph_q;
    we = 1'b0; wa = idx_q[IdxW-1:0]; wd = '0; ra = idx_q[IdxW-1:0];
    sts_o = '0;
    case (op_i)
      ffba_pkg::OP_LOAD: begin
        idx_d = '0; start_d = '0; ph_d = '0;
        rsp_d = '0;
      end
      ffba_pkg::OP_INIT: begin
        we = 1'b1;
        wd = (idx_q == '0) ? {1'b0, region_i} : 17'd0;
        idx_d = idx_q + 1'b1;
        cnt_d = CntW'(1);
        sts_o.init_done = (idx_q == CntW'(MaxBlocks - 1));
      end
      ffba_pkg::OP_READ: ;
      ffba_pkg::OP_EXAM: begin
        if (idx_q >= cnt_q) begin
          sts_o.miss = 1'b1;
          rsp_d.status = req_q.func ? ffba_pkg::ST_BADFREE : ffba_pkg::ST_NOFIT;
        end else if (req_q.func == ffba_pkg::FUNC_ALLOC) begin
          if (!rd_q[16] && rd_q[15:0] >= need) begin
            sts_o.hit = 1'b1;
            hit_d = idx_q;
            left_d = rd_q[15:0] - need;
            rsp_d.granted_start = start_q[15:0];
            if ((rd_q[15:0] != need) && ((rd_q[15:0] - need) >= thresh_i)
                && (cnt_q != CntW'(MaxBlocks))) begin
              sts_o.split = 1'b1;
              we = 1'b1; wd = {1'b1, need};
              rsp_d.granted_size = need;
              idx_d = cnt_q;      // shift from top down
              ph_d = '0;
            end else begin
              we = 1'b1; wd = {1'b1, rd_q[15:0]};
              rsp_d.granted_size = rd_q[15:0];
            end
          end else begin
            start_d = start_q + {1'b0, rd_q[15:0]};
            idx_d = idx_q + 1'b1;
          end
        end else begin
          if (start_q == {1'b0, req_q.free_start} && rd_q[16]) begin
            sts_o.hit = 1'b1;
            hit_d = idx_q;
            acc_d = rd_q[15:0];
            we = 1'b1; wd = {1'b0, rd_q[15:0]};
            idx_d = idx_q + 1'b1;
            ph_d = '0;
          end else if (start_q > {1'b0, req_q.free_start}) begin
            sts_o.miss = 1'b1;
            rsp_d.status = ffba_pkg::ST_BADFREE;
          end else begin
            start_d = start_q + {1'b0, rd_q[15:0]};
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ffba_pkg::OP_UP: begin
        // move entry idx-1 to idx until idx == hit+1, then write leftover
        if (idx_q == hit_q + 1'b1) begin
          we = 1'b1; wa = idx_q[IdxW-1:0]; wd = {1'b0, left_q};
          cnt_d = cnt_q + 1'b1;
          sts_o.shift_done = 1'b1;
        end else begin
          ra = IdxW'(idx_q - 1'b1);
          if (ph_q[0]) begin
            we = 1'b1; wd = rd_q;
            idx_d = idx_q - 1'b1;
          end
          ph_d = {1'b0, ~ph_q[0]};
        end
      end
      ffba_pkg::OP_DN: begin
        // remove entry at idx: move idx+1 down until top
        if (idx_q + 1'b1 >= cnt_q) begin
          we = 1'b1; wd = '0;
          cnt_d = cnt_q - 1'b1;
          sts_o.shift_done = 1'b1;
        end else begin
          ra = IdxW'(idx_q + 1'b1);
          if (ph_q[0]) begin
            we = 1'b1; wd = rd_q;
            idx_d = idx_q + 1'b1;
          end
          ph_d = {1'b0, ~ph_q[0]};
        end
      end
      ffba_pkg::OP_NEXT: begin
        // idx = hit+1; ph0 issue read, ph1 decide
        if (idx_q >= cnt_q) begin
          sts_o.shift_done = 1'b1;
          idx_d = hit_q;
          ph_d = '0;
        end else if (!ph_q[0]) begin
          ph_d = 2'd1;
        end else begin
          sts_o.shift_done = 1'b1;
          ph_d = '0;
          if (!rd_q[16]) begin
            sts_o.merge = 1'b1;
            acc_d = acc_q + rd_q[15:0];
            we = 1'b1; wa = hit_q[IdxW-1:0]; wd = {1'b0, acc_q + rd_q[15:0]};
            // idx stays at hit+1 for the removal
          end else begin
            idx_d = hit_q;
          end
        end
      end
      ffba_pkg::OP_PREV: begin
        // read hit-1; on a merge, idx is set to hit for the removal
        ra = IdxW'(hit_q - 1'b1);
        if (hit_q == '0) begin
          sts_o.shift_done = 1'b1;
        end else if (!ph_q[0]) begin
          ph_d = 2'd1;
        end else begin
          sts_o.shift_done = 1'b1;
          ph_d = '0;
          if (!rd_q[16]) begin
            sts_o.merge = 1'b1;
            we = 1'b1; wa = IdxW'(hit_q - 1'b1);
            wd = {1'b0, rd_q[15:0] + acc_q};
            idx_d = hit_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign rsp_o = rsp_q;

endmodule

FILE: hdl/ffba_ctrl.sv
module ffba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             reinit_i,
  input  logic             func_i,
  input  ffba_pkg::sts_t   sts_i,
  output ffba_pkg::op_e    op_o,
  output logic             busy_o,
  output logic             done_o
);

  ffba_pkg::state_e state_q, state_d;
  logic             func_q;
  logic             prev_dn_q;   // removal after a merge into the previous entry

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ffba_pkg::S_INIT;
      func_q    <= 1'b0;
      prev_dn_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ffba_pkg::S_IDLE && start_i) func_q <= func_i;
      if (state_q == ffba_pkg::S_FREE_PREV) prev_dn_q <= 1'b1;
      else if (state_q == ffba_pkg::S_IDLE) prev_dn_q <= 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    op_o    = ffba_pkg::OP_NONE;
    done_o  = 1'b0;
    busy_o  = (state_q != ffba_pkg::S_IDLE);
    case (state_q)
      ffba_pkg::S_IDLE: begin
        if (reinit_i) begin
          state_d = ffba_pkg::S_INIT;
          op_o = ffba_pkg::OP_LOAD;
        end else if (start_i) begin
          op_o = ffba_pkg::OP_LOAD;
          state_d = ffba_pkg::S_RD;
        end
      end
      ffba_pkg::S_INIT: begin
        op_o = ffba_pkg::OP_INIT;
        if (sts_i.init_done) state_d = ffba_pkg::S_IDLE;
      end
      ffba_pkg::S_RD: begin
        op_o = ffba_pkg::OP_READ;
        state_d = ffba_pkg::S_SCAN;
      end
      ffba_pkg::S_SCAN: begin
        op_o = ffba_pkg::OP_EXAM;
        if (sts_i.miss) state_d = ffba_pkg::S_RESP;
        else if (sts_i.hit) begin
          if (func_q == ffba_pkg::FUNC_FREE) state_d = ffba_pkg::S_FREE_NEXT;
          else if (sts_i.split) state_d = ffba_pkg::S_SHIFT_UP;
          else state_d = ffba_pkg::S_RESP;
        end else state_d = ffba_pkg::S_RD;
      end
      ffba_pkg::S_SHIFT_UP: begin
        op_o = ffba_pkg::OP_UP;
        if (sts_i.shift_done) state_d = ffba_pkg::S_RESP;
      end
      ffba_pkg::S_FREE_NEXT: begin
        op_o = ffba_pkg::OP_NEXT;
        if (sts_i.shift_done)
          state_d = sts_i.merge ? ffba_pkg::S_SHIFT_DN : ffba_pkg::S_FREE_PREV;
      end
      ffba_pkg::S_SHIFT_DN: begin
        op_o = ffba_pkg::OP_DN;
        if (sts_i.shift_done)
          state_d = prev_dn_q ? ffba_pkg::S_RESP : ffba_pkg::S_FREE_PREV;
      end
      ffba_pkg::S_FREE_PREV: begin
        op_o = ffba_pkg::OP_PREV;
        if (sts_i.shift_done)
          state_d = sts_i.merge ? ffba_pkg::S_SHIFT_DN : ffba_pkg::S_RESP;
      end
      ffba_pkg::S_RESP: begin
        done_o = 1'b1;
        state_d = ffba_pkg::S_IDLE;
      end
      default: state_d = ffba_pkg::S_IDLE;
    endcase
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> state_q == ffba_pkg::S_IDLE) else $error("done not followed by idle");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffba_pkg::S_IDLE) |-> !busy_o) else $error("busy in idle");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !reinit_i) |=> state_q == ffba_pkg::S_RD)
    else $error("start not taken");

endmodule

FILE: hdl/first_fit_block_allocator_unit.sv
// channel  | handshake             | payload
// request  | start_i / busy_o      | req_i (ffba_pkg::req_t)
// result   | done_o strobe         | rsp_o (ffba_pkg::rsp_t)
// config   | APB psel/penable      | region_size @0x0, split_threshold @0x4
// A request scans the table one entry at a time, each read and then examined,
// then moves entries one at a time when a split inserts or a merge removes an
// entry. busy_o is high until a request is done; requests never overlap.
// After reset, and after each region_size write, a clear pass over all MaxBlocks
// entries runs with busy_o high. Results cannot be stalled.
module first_fit_block_allocator_unit #(
  parameter int unsigned MaxBlocks = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  ffba_pkg::req_t  req_i,
  output logic            done_o,
  output ffba_pkg::rsp_t  rsp_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int unsigned IdxW = $clog2(MaxBlocks);
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);

  logic [15:0] region_q, thresh_q;
  logic        wr, reinit_q;
  logic        ctrl_busy;
  logic [1:0]  reg_idx;
  ffba_pkg::op_e  op;
  ffba_pkg::sts_t sts;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = {1'b0, paddr[2]};
  // a pending table clear holds off new requests
  assign busy_o  = ctrl_busy || reinit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= ffba_pkg::RESET_REGION;
      thresh_q <= ffba_pkg::RESET_THRESH;
      reinit_q <= 1'b0;
    end else begin
      if (wr && reg_idx == ffba_pkg::REG_REGION) region_q <= pwdata[15:0];
      if (wr && reg_idx == ffba_pkg::REG_THRESH) thresh_q <= pwdata[15:0];
      if (wr && reg_idx == ffba_pkg::REG_REGION) reinit_q <= 1'b1;
      else if (!ctrl_busy) reinit_q <= 1'b0;
    end
  end

  always_comb begin
    case (reg_idx)
      ffba_pkg::REG_REGION: prdata = {16'd0, region_q};
      ffba_pkg::REG_THRESH: prdata = {16'd0, thresh_q};
      default:              prdata = '0;
    endcase
  end

  ffba_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i,
    .reinit_i(reinit_q),
    .func_i(req_i.func),
    .sts_i(sts), .op_o(op), .busy_o(ctrl_busy), .done_o
  );

  ffba_datapath #(.MaxBlocks(MaxBlocks), .IdxW(IdxW), .CntW(CntW)) u_dp (
    .clk_i, .rst_ni, .op_i(op), .req_i,
    .region_i(region_q), .thresh_i(thresh_q),
    .sts_o(sts), .rsp_o
  );

endmodule

FILE: tb/tb_top.sv
module tb_top;

  localparam int unsigned NumBlocks = 64;
  localparam int unsigned CycleLimit = 3000000;

  // Mirror of the block table plus the queue of results still to come.
  class alloc_scoreboard;
    logic [15:0] sizes[NumBlocks];
    bit          used[NumBlocks];
    int unsigned count;
    logic [15:0] region;
    logic [15:0] thresh;
    ffba_pkg::rsp_t rsp_q[$];
    int unsigned errors;

    function new();
      region = ffba_pkg::RESET_REGION;
      thresh = ffba_pkg::RESET_THRESH;
      errors = 0;
      init_table();
    endfunction

    function void init_table();
      for (int i = 0; i < NumBlocks; i++) begin
        sizes[i] = '0;
        used[i]  = 1'b0;
      end
      sizes[0] = region;
      count    = 1;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == ffba_pkg::REG_REGION) begin
        region = val;
        init_table();
      end else if (idx == ffba_pkg::REG_THRESH) begin
        thresh = val;
      end
    endfunction

    function void drop_entry(int unsigned idx);
      for (int unsigned j = idx; j + 1 < count; j++) begin
        sizes[j] = sizes[j+1];
        used[j]  = used[j+1];
      end
      count--;
      sizes[count] = '0;
      used[count]  = 1'b0;
    endfunction

    function ffba_pkg::rsp_t predict(ffba_pkg::req_t r);
      ffba_pkg::rsp_t res;
      int unsigned want, left, offs;
      int          hit;
      res  = '0;
      offs = 0;
      hit  = -1;
      if (r.func == ffba_pkg::FUNC_ALLOC) begin
        want = (r.request_size == 0) ? 1 : r.request_size;
        res.status = ffba_pkg::ST_NOFIT;
        for (int unsigned i = 0; i < count; i++) begin
          if (!used[i] && sizes[i] >= want) begin
            left    = sizes[i] - want;
            used[i] = 1'b1;
            if (left > 0 && left >= thresh && count < NumBlocks) begin
              sizes[i] = want[15:0];
              for (int unsigned j = count; j > i + 1; j--) begin
                sizes[j] = sizes[j-1];
                used[j]  = used[j-1];
              end
              sizes[i+1] = left[15:0];
              used[i+1]  = 1'b0;
              count++;
              res.granted_size = want[15:0];
            end else begin
              res.granted_size = sizes[i];
            end
            res.granted_start = offs[15:0];
            res.status        = ffba_pkg::ST_DONE;
            break;
          end
          offs += sizes[i];
        end
      end else begin
        for (int unsigned i = 0; i < count; i++) begin
          if (offs == r.free_start && used[i]) begin
            hit = i;
            break;
          end
          if (offs > r.free_start) break;
          offs += sizes[i];
        end
        if (hit < 0) begin
          res.status = ffba_pkg::ST_BADFREE;
        end else begin
          res.status = ffba_pkg::ST_DONE;
          used[hit]  = 1'b0;
          if (hit + 1 < count && !used[hit+1]) begin
            sizes[hit] = sizes[hit] + sizes[hit+1];
            drop_entry(hit + 1);
          end
          if (hit > 0 && !used[hit-1]) begin
            sizes[hit-1] = sizes[hit-1] + sizes[hit];
            drop_entry(hit);
          end
        end
      end
      return res;
    endfunction

    function void note(ffba_pkg::req_t r);
      rsp_q.push_back(predict(r));
    endfunction

    function void check(ffba_pkg::rsp_t got);
      ffba_pkg::rsp_t want;
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = rsp_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status exp %h act %h", $time, want.status, got.status);
        errors++;
      end
      if (got.granted_start !== want.granted_start) begin
        $display("%0t: granted_start exp %h act %h", $time, want.granted_start,
                 got.granted_start);
        errors++;
      end
      if (got.granted_size !== want.granted_size) begin
        $display("%0t: granted_size exp %h act %h", $time, want.granted_size,
                 got.granted_size);
        errors++;
      end
    endfunction

    // start of a random allocated block, or noise when none is held
    function logic [15:0] held_start();
      int unsigned starts[$];
      int unsigned offs;
      offs = 0;
      for (int unsigned i = 0; i < count; i++) begin
        if (used[i]) starts.push_back(offs);
        offs += sizes[i];
      end
      if (starts.size() == 0) return 16'($urandom);
      return 16'(starts[$urandom_range(0, starts.size() - 1)]);
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  ffba_pkg::req_t req_i;
  logic           done_o;
  ffba_pkg::rsp_t rsp_o;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  alloc_scoreboard sb;
  int unsigned     cycles;
  int unsigned     burst_left;

  first_fit_block_allocator_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check(rsp_o);
  end

  // all tasks are entered right after a rising edge
  task automatic send(ffba_pkg::req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    sb.note(r);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.rsp_q.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic alloc(logic [15:0] sz);
    ffba_pkg::req_t r;
    r.func         = ffba_pkg::FUNC_ALLOC;
    r.request_size = sz;
    r.free_start   = 16'($urandom);
    send(r);
  endtask

  task automatic release_at(logic [15:0] st);
    ffba_pkg::req_t r;
    r.func         = ffba_pkg::FUNC_FREE;
    r.request_size = 16'($urandom);
    r.free_start   = st;
    send(r);
  endtask

  // mostly frees of held blocks and allocations of up to max_sz; some noise
  task automatic random_phase(int unsigned n, int unsigned max_sz);
    int unsigned pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) alloc(16'($urandom_range(1, max_sz)));
      else if (pick < 55) alloc(16'($urandom));
      else if (pick < 57) alloc(16'h0);
      else if (pick < 88) release_at(sb.held_start());
      else if (pick < 94) release_at(sb.held_start() + 16'($urandom_range(1, 3)));
      else release_at(16'($urandom));
    end
  endtask

  initial begin
    sb         = new();
    cycles     = 0;
    burst_left = 10;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    req_i      = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config, split edge, zero request, bad frees
    alloc(16'h0);
    alloc(16'hffff);
    alloc(16'd9899);
    alloc(16'd1);
    release_at(16'd0);
    release_at(16'd0);
    release_at(16'hffff);
    release_at(16'd1);
    release_at(16'd1);
    release_at(16'd9900);
    // zero leftover with zero threshold
    write_reg(ffba_pkg::REG_THRESH, 16'd0);
    write_reg(ffba_pkg::REG_REGION, 16'd50);
    alloc(16'd50);
    alloc(16'd1);
    release_at(16'd0);
    alloc(16'd20);
    alloc(16'd30);
    release_at(16'd20);
    release_at(16'd0);
    // empty region
    write_reg(ffba_pkg::REG_REGION, 16'd0);
    alloc(16'd1);
    release_at(16'd0);
    write_reg(ffba_pkg::REG_REGION, 16'd1);
    alloc(16'd1);
    alloc(16'd1);
    release_at(16'd0);

    write_reg(ffba_pkg::REG_REGION, ffba_pkg::RESET_REGION);
    write_reg(ffba_pkg::REG_THRESH, ffba_pkg::RESET_THRESH);
    random_phase(240, 1500);
    // small requests on a large region fill the table
    write_reg(ffba_pkg::REG_REGION, 16'hffff);
    write_reg(ffba_pkg::REG_THRESH, 16'd0);
    random_phase(240, 4);
    write_reg(ffba_pkg::REG_THRESH, 16'hffff);
    random_phase(200, 8000);
    write_reg(ffba_pkg::REG_REGION, 16'd300);
    write_reg(ffba_pkg::REG_THRESH, 16'd3);
    random_phase(220, 20);
    write_reg(ffba_pkg::REG_REGION, 16'd1);
    random_phase(60, 2);
    for (int p = 0; p < 4; p++) begin
      write_reg(ffba_pkg::REG_REGION, 16'($urandom_range(1, 65535)));
      write_reg(ffba_pkg::REG_THRESH, 16'($urandom_range(0, 400)));
      random_phase(195, $urandom_range(2, 3000));
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.rsp_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ffba_pkg.sv
hdl/ffba_datapath.sv
hdl/ffba_ctrl.sv
hdl/first_fit_block_allocator_unit.sv
tb/tb_top.sv
